// ===== design/srgb_pixel_encoder_defines.svh =====
// Assertion macros used by the sRGB pixel encoder source.
`ifndef SRGB_PIXEL_ENCODER_DEFINES_SVH
`define SRGB_PIXEL_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define SRGB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srgb assertion failed");
`define SRGB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srgb assertion failed");
`else
`define SRGB_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRGB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/srgb_pkg.sv =====
package srgb_pkg;

  localparam int IN_W          = 16;
  localparam int CODE_W        = 8;
  localparam int CODES         = 1 << CODE_W;
  localparam int FRAC_BITS_DEF = 13;

  // Curve constants in integer form.
  localparam longint unsigned LIN_KNEE_NUM  = 64'd31308;
  localparam longint unsigned LIN_KNEE_DEN  = 64'd10000000;
  localparam longint unsigned LIN_SLOPE     = 64'd1292;
  localparam longint unsigned LIN_SLOPE_DEN = 64'd100;
  localparam longint unsigned CODE_SCALE2   = 64'd510;
  localparam int              POW_A_MUL     = 20;
  localparam int              POW_A_OFS     = 561;
  localparam int              POW_B         = 10761;
  localparam int              POW_NUM_EXP   = 5;
  localparam int              POW_DEN_EXP   = 12;
  localparam int              POW_SHIFT     = 5;
  localparam int              BIG_W         = 384;

  // Whether the encoded value of n / 2^s reaches (2k-1)/510. The power
  // segment compares n^5 * 10761^12 against (20(2k-1)+561)^12 * 32^s exactly.
  function automatic bit srgb_reaches(longint unsigned n, int s, int k);
    longint unsigned scale;
    longint unsigned odd;
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] a_big;
    bit               res;
    scale = 64'd1 << s;
    odd   = 64'(2 * k - 1);
    if (n * LIN_KNEE_DEN <= LIN_KNEE_NUM * scale) begin
      res = (LIN_SLOPE * CODE_SCALE2 * n) >= (LIN_SLOPE_DEN * odd * scale);
    end else begin
      lhs   = BIG_W'(1);
      rhs   = BIG_W'(1);
      a_big = BIG_W'(POW_A_MUL * (2 * k - 1) + POW_A_OFS);
      for (int i = 0; i < POW_NUM_EXP; i++) begin
        lhs = lhs * BIG_W'(n);
      end
      for (int i = 0; i < POW_DEN_EXP; i++) begin
        lhs = lhs * BIG_W'(POW_B);
        rhs = rhs * a_big;
      end
      rhs = rhs << (POW_SHIFT * s);
      res = (lhs >= rhs);
    end
    return res;
  endfunction

  // Smallest input level, at scale 2^(frac_bits+1), whose code is at least k.
  function automatic int srgb_threshold(int frac_bits, int k);
    int s;
    int lo;
    int hi;
    int mid;
    s  = frac_bits + 1;
    lo = 0;
    hi = 1 << s;
    if (k == 0) begin
      hi = 0;
    end
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (srgb_reaches(longint'(mid), s, k)) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return lo;
  endfunction

endpackage

// ===== design/srgb_in_if.sv =====
interface srgb_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [srgb_pkg::IN_W-1:0]    in_red;
  logic signed [srgb_pkg::IN_W-1:0]    in_green;
  logic signed [srgb_pkg::IN_W-1:0]    in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                output ready);
endinterface

// ===== design/srgb_out_if.sv =====
interface srgb_out_if;
  logic                          valid;
  logic                          ready;
  logic [srgb_pkg::CODE_W-1:0]   out_red;
  logic [srgb_pkg::CODE_W-1:0]   out_green;
  logic [srgb_pkg::CODE_W-1:0]   out_blue;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                output ready);
endinterface

// ===== design/srgb_chan.sv =====
// One colour channel: input mapping and clamp, then an eight-step search of
// the threshold ROM, one code bit per stage.
module srgb_chan #(
  parameter int FRAC_BITS = srgb_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [srgb_pkg::CODE_W:0]          adv,
  input  logic                               remap,
  input  logic signed [srgb_pkg::IN_W-1:0]   x,
  output logic [srgb_pkg::CODE_W-1:0]        code
);

  localparam int STEPS = srgb_pkg::CODE_W;
  localparam int IN_W  = srgb_pkg::IN_W;
  localparam int NW    = FRAC_BITS + 2;
  localparam int TW    = ((IN_W + 1 > NW) ? IN_W + 1 : NW) + 1;

  localparam logic signed [TW-1:0] ONE_OFS = TW'(1) <<< FRAC_BITS;
  localparam logic signed [TW-1:0] TOP     = TW'(1) <<< (FRAC_BITS + 1);

  typedef logic [NW-1:0] thr_tab_t [srgb_pkg::CODES];

  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    for (int k = 0; k < srgb_pkg::CODES; k++) begin
      tab[k] = NW'(srgb_pkg::srgb_threshold(FRAC_BITS, k));
    end
    return tab;
  endfunction

  localparam thr_tab_t THR = build_thr();

  logic signed [TW-1:0]  xe;
  logic signed [TW-1:0]  t;
  logic [NW-1:0]         n0;

  logic [NW-1:0]          n_q    [STEPS];
  logic [NW-1:0]          thr_q  [STEPS];
  logic [STEPS-1:0]       code_q [1:STEPS];

  always_comb begin
    xe = {{(TW - IN_W){x[IN_W-1]}}, x};
    t  = remap ? (xe + ONE_OFS) : (xe <<< 1);
    if (t < 0) begin
      n0 = '0;
    end else if (t > TOP) begin
      n0 = TOP[NW-1:0];
    end else begin
      n0 = t[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      n_q[0]   <= n0;
      thr_q[0] <= THR[STEPS'(1) << (STEPS - 1)];
    end
  end

  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    localparam int B = STEPS - j;
    logic [STEPS-1:0] code_prev;
    logic [STEPS-1:0] code_nx;

    if (j == 1) begin : g_first
      assign code_prev = '0;
    end else begin : g_rest
      assign code_prev = code_q[j-1];
    end

    assign code_nx = code_prev |
                     ((n_q[j-1] >= thr_q[j-1]) ? (STEPS'(1) << B) : '0);

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        code_q[j] <= code_nx;
      end
    end

    if (j < STEPS) begin : g_fwd
      always_ff @(posedge clk) begin
        if (adv[j]) begin
          n_q[j]   <= n_q[j-1];
          thr_q[j] <= THR[code_nx | (STEPS'(1) << (B - 1))];
        end
      end
    end
  end

  assign code = code_q[STEPS];

endmodule

// ===== design/srgb_pixel_encoder.sv =====
// sRGB pixel encoder. Each transfer on pix_in carries one linear RGB pixel,
// three signed fixed-point channels with FRAC_BITS fraction bits (Q3.13 by
// default), and yields one transfer on pix_out with three 8-bit sRGB codes,
// rounded to nearest with halves rounded up and clamped to 0..255. With
// remap written to 1 through cfg_we/cfg_wdata each channel is first
// taken from [-1,1] to [0,1]; write it only while no pixel is in flight. The
// block accepts one pixel per clock while the output is ready. An input
// register holds the mapped and clamped value, then eight search stages
// each settle one code bit with one threshold comparison and one read of
// the constant threshold ROM. The ROM holds, for every code, the smallest
// clamped input level that reaches it, and is built exactly at elaboration.
// Stages fill bubbles under back-pressure, so input transfers continue while
// a finished pixel waits at the output until the pipeline is full.
`include "srgb_pixel_encoder_defines.svh"

module srgb_pixel_encoder #(
  parameter int FRAC_BITS = srgb_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  srgb_in_if.sink    pix_in,
  srgb_out_if.source pix_out
);

  localparam int STEPS = srgb_pkg::CODE_W;

  logic               remap;
  logic [STEPS:0]     valid_q;
  logic [STEPS:0]     adv;

  // The configuration register keeps only its single bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      remap <= 1'b0;
    end else if (cfg_we) begin
      remap <= cfg_wdata;
    end
  end

  // A stage moves when it is empty or when the stage after it moves, so
  // empty slots close up even while the output is stalled.
  always_comb begin
    adv[STEPS] = !valid_q[STEPS] || pix_out.ready;
    for (int i = STEPS - 1; i >= 0; i--) begin
      adv[i] = !valid_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= pix_in.valid;
      end
      for (int i = 1; i <= STEPS; i++) begin
        if (adv[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // No input transfer is taken while the block is held in reset.
  assign pix_in.ready  = adv[0] && !rst;
  assign pix_out.valid = valid_q[STEPS];

  // The three channels share the stage control and differ only in data.
  srgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk   (clk),
    .adv   (adv),
    .remap (remap),
    .x     (pix_in.in_red),
    .code  (pix_out.out_red)
  );

  srgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk   (clk),
    .adv   (adv),
    .remap (remap),
    .x     (pix_in.in_green),
    .code  (pix_out.out_green)
  );

  srgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk   (clk),
    .adv   (adv),
    .remap (remap),
    .x     (pix_in.in_blue),
    .code  (pix_out.out_blue)
  );

  // Input is refused only when every stage holds a pixel and the output stalls.
  `SRGB_ASSERT_IMP(a_ready_full, clk, rst, !pix_in.ready, (&valid_q) && !pix_out.ready)
  // An accepted pixel always lands in the first stage.
  `SRGB_ASSERT_NXT(a_accept_lands, clk, rst, pix_in.valid && pix_in.ready, valid_q[0])
  // A stalled output keeps its pixel in the last stage.
  `SRGB_ASSERT_NXT(a_out_hold, clk, rst, valid_q[STEPS] && !pix_out.ready, valid_q[STEPS])

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for srgb_pixel_encoder.
//
// Pixels are queued by the stimulus process and presented on pix_in by a
// clocked driver. At every input transfer the driver works out the three sRGB
// codes the block should produce and appends them to a store of expected
// codes. A clocked monitor takes each output transfer and compares it, channel
// by channel, with the oldest expected codes.
//
// The expected codes come from a table built once at time zero. For every
// code k it holds the smallest clamped input level (at scale 2^(FRAC+1)) whose
// encoded value reaches (k - 0.5) / 255. The boundary is decided exactly in
// integer arithmetic, so the table is free of any floating-point rounding.
module tb_top;

  localparam int FRAC       = srgb_pkg::FRAC_BITS_DEF;
  localparam int LVL_SHIFT  = FRAC + 1;
  localparam int LEVEL_TOP  = 1 << LVL_SHIFT;
  localparam int HALF_LEVEL = 1 << FRAC;
  localparam int MAX_CODE   = 255;
  localparam int WIDE_W     = 320;
  localparam int CYCLE_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_PIXELS  = 344;

  typedef struct packed {
    logic signed [srgb_pkg::IN_W-1:0] red;
    logic signed [srgb_pkg::IN_W-1:0] green;
    logic signed [srgb_pkg::IN_W-1:0] blue;
  } lin_pixel_t;

  typedef struct packed {
    logic [srgb_pkg::CODE_W-1:0] red;
    logic [srgb_pkg::CODE_W-1:0] green;
    logic [srgb_pkg::CODE_W-1:0] blue;
  } srgb_code_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  srgb_in_if  pix_in ();
  srgb_out_if pix_out ();

  srgb_pixel_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .pix_in   (pix_in),
    .pix_out  (pix_out)
  );

  // Pixels waiting to be driven, and codes waiting to be seen at the output.
  lin_pixel_t pixel_queue[$];
  srgb_code_t pending_codes[$];

  // The remap setting that the block holds, mirrored at each register write.
  bit remap_setting = 1'b0;

  // code_floor[k] is the smallest level that encodes to k or above;
  // code_of_level is the code for every clamped level.
  int unsigned code_floor[1:MAX_CODE];
  logic [7:0]  code_of_level[0:LEVEL_TOP];

  int unsigned cyc = 0;
  int unsigned mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run-away guard: a correct run finishes well inside this many cycles.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Does the sRGB curve at level lvl / 2^(FRAC+1) reach (2k-1)/510?
  // Below the knee this is 12.92*v >= (2k-1)/510. Above it the power segment
  // rearranges to v^(5/12) >= (20(2k-1)+561)/10761, which after raising both
  // sides to the twelfth power becomes lvl^5 * 10761^12 >= A^12 * 2^(5*shift).
  function automatic bit curve_reaches(int unsigned lvl, int unsigned k);
    longint unsigned n;
    longint unsigned odd;
    logic [WIDE_W-1:0] lhs;
    logic [WIDE_W-1:0] rhs;
    bit hit;
    n   = lvl;
    odd = 2 * k - 1;
    if (n * 64'd10000000 <= 64'd31308 * LEVEL_TOP) begin
      hit = (64'd1292 * 64'd510 * n) >= (64'd100 * odd * LEVEL_TOP);
    end else begin
      lhs = WIDE_W'(1);
      rhs = WIDE_W'(1);
      for (int i = 0; i < 5; i++) begin
        lhs = lhs * WIDE_W'(n);
      end
      for (int i = 0; i < 12; i++) begin
        lhs = lhs * WIDE_W'(10761);
        rhs = rhs * WIDE_W'(20 * odd + 561);
      end
      rhs = rhs << (5 * LVL_SHIFT);
      hit = lhs >= rhs;
    end
    return hit;
  endfunction

  // Binary search per code for its floor level, then a single sweep to fill
  // the per-level table. The floors rise with the code, so the sweep only
  // ever moves forward.
  function automatic void build_code_table();
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned k;
    for (int c = 1; c <= MAX_CODE; c++) begin
      lo = 0;
      hi = LEVEL_TOP;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (curve_reaches(mid, c)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      code_floor[c] = lo;
    end
    k = 0;
    for (int lvl = 0; lvl <= LEVEL_TOP; lvl++) begin
      while (k < MAX_CODE && lvl >= code_floor[k + 1]) begin
        k++;
      end
      code_of_level[lvl] = 8'(k);
    end
  endfunction

  // Map one channel to its clamped level: doubled without remap, or offset
  // by one half of full scale with remap, which is (v + 1) / 2 exactly.
  function automatic int clamp_level(logic signed [srgb_pkg::IN_W-1:0] f, bit remap);
    int lvl;
    lvl = remap ? int'(f) + HALF_LEVEL : 2 * int'(f);
    if (lvl < 0) begin
      lvl = 0;
    end
    if (lvl > LEVEL_TOP) begin
      lvl = LEVEL_TOP;
    end
    return lvl;
  endfunction

  function automatic srgb_code_t encode_pixel(lin_pixel_t px);
    srgb_code_t codes;
    codes.red   = code_of_level[clamp_level(px.red, remap_setting)];
    codes.green = code_of_level[clamp_level(px.green, remap_setting)];
    codes.blue  = code_of_level[clamp_level(px.blue, remap_setting)];
    return codes;
  endfunction

  // Both sides pause in roughly a quarter of cycles, except across one quiet
  // window where the stream runs flat out in both directions.
  function automatic bit take_gap();
    return ($urandom_range(99) < 24) && !(cyc >= 700 && cyc < 1100);
  endfunction

  // One random channel value. A third of draws span the full 16-bit field
  // so that every bit toggles and both clamps are hit; most of the rest land
  // inside the encoded range; the remainder sit on or next to a code
  // boundary, where the rounding decision is most delicate.
  function automatic logic signed [srgb_pkg::IN_W-1:0] random_field(bit remap);
    int sel;
    int lvl;
    int f;
    sel = $urandom_range(99);
    if (sel < 35) begin
      f = int'($urandom_range(65535));
    end else if (sel < 75) begin
      f = remap ? int'($urandom_range(LEVEL_TOP)) - HALF_LEVEL
                : int'($urandom_range(HALF_LEVEL));
    end else begin
      lvl = int'(code_floor[$urandom_range(MAX_CODE, 1)]) + int'($urandom_range(2)) - 1;
      f = remap ? lvl - HALF_LEVEL : lvl >>> 1;
    end
    return srgb_pkg::IN_W'(f);
  endfunction

  task automatic queue_random_pixels(int count);
    lin_pixel_t px;
    for (int i = 0; i < count; i++) begin
      px.red   = random_field(remap_setting);
      px.green = random_field(remap_setting);
      px.blue  = random_field(remap_setting);
      pixel_queue.push_back(px);
    end
  endtask

  // Hand-picked pixels: the field extremes, zero and its neighbours, full
  // scale and either side of it, minus one for the remap case, both clamps,
  // and values straddling the knee between the linear and power segments
  // in either mapping.
  task automatic queue_directed_pixels();
    pixel_queue.push_back('{-16'sd32768, 16'sd32767, 16'sd0});
    pixel_queue.push_back('{16'sd0, -16'sd1, 16'sd1});
    pixel_queue.push_back('{16'sd8192, 16'sd8191, 16'sd8193});
    pixel_queue.push_back('{-16'sd8192, -16'sd8191, -16'sd8193});
    pixel_queue.push_back('{16'sd25, 16'sd26, 16'sd27});
    pixel_queue.push_back('{-16'sd8166, -16'sd8141, -16'sd8140});
    pixel_queue.push_back('{16'sd4096, 16'sd2048, 16'sd1024});
    pixel_queue.push_back('{16'sd16384, -16'sd16384, 16'sd32767});
    pixel_queue.push_back('{16'sd1, 16'sd2, 16'sd3});
    pixel_queue.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
    pixel_queue.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
    pixel_queue.push_back('{16'sd100, 16'sd1000, 16'sd5000});
  endtask

  // Wait until every queued pixel has made its transfer and every expected
  // result has come back, then let the pipeline settle before anything
  // else touches the block.
  task automatic wait_until_idle();
    while (pixel_queue.size() != 0 || pix_in.valid || pending_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_remap(bit value);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    remap_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: presents the next queued pixel whenever the slot is free, and on
  // each input transfer records the codes that pixel must produce.
  always @(posedge clk) begin : drive_pixels
    lin_pixel_t nxt;
    if (rst) begin
      pix_in.valid <= 1'b0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        pending_codes.push_back(encode_pixel('{pix_in.in_red, pix_in.in_green,
                                               pix_in.in_blue}));
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (pixel_queue.size() != 0 && !take_gap()) begin
          nxt = pixel_queue.pop_front();
          pix_in.valid    <= 1'b1;
          pix_in.in_red   <= nxt.red;
          pix_in.in_green <= nxt.green;
          pix_in.in_blue  <= nxt.blue;
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: applies random back-pressure and checks each output transfer
  // against the oldest expected codes.
  always @(posedge clk) begin : check_codes
    srgb_code_t want;
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (pending_codes.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual r=%0d g=%0d b=%0d",
                   $time, pix_out.out_red, pix_out.out_green, pix_out.out_blue);
          mismatches++;
        end else begin
          want = pending_codes.pop_front();
          if (pix_out.out_red !== want.red) begin
            $display("%0t: red mismatch, expected %0d, actual %0d",
                     $time, want.red, pix_out.out_red);
            mismatches++;
          end
          if (pix_out.out_green !== want.green) begin
            $display("%0t: green mismatch, expected %0d, actual %0d",
                     $time, want.green, pix_out.out_green);
            mismatches++;
          end
          if (pix_out.out_blue !== want.blue) begin
            $display("%0t: blue mismatch, expected %0d, actual %0d",
                     $time, want.blue, pix_out.out_blue);
            mismatches++;
          end
        end
      end
      pix_out.ready <= !take_gap();
    end
  end

  // Stimulus: four phases alternating the remap setting. The first two start
  // with the hand-picked pixels so that both mappings see every special case.
  initial begin
    pix_in.valid    = 1'b0;
    pix_in.in_red   = '0;
    pix_in.in_green = '0;
    pix_in.in_blue  = '0;
    pix_out.ready   = 1'b0;
    build_code_table();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      write_remap(phase[0]);
      if (phase < 2) begin
        queue_directed_pixels();
      end
      queue_random_pixels(PHASE_PIXELS);
      wait_until_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
